FILE: hw/rtl/lrt_pkg.sv
`timescale 1ns / 1ps

package lrt_pkg;

  localparam int ENTRIES = 16;
  localparam int ENT_W   = 4;

  localparam logic [1:0] ACT_USE       = 2'd0;
  localparam logic [1:0] ACT_DETACH    = 2'd1;
  localparam logic [1:0] ACT_RECLAIM   = 2'd2;
  localparam logic [1:0] ACT_HIBERNATE = 2'd3;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_MOVE   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [ENT_W-1:0] entry;
    logic             requester_present;
  } in_t;

  typedef struct packed {
    logic [ENT_W-1:0] victim_entry;
    logic             victim_found;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [ENT_W-1:0] key;
  } cell_cmd_t;

  // toward the tail
  typedef struct packed {
    logic [ENT_W-1:0] entry;
    logic             valid;
    logic             stop;
    logic             hit;
  } fwd_link_t;

  // toward the head
  typedef struct packed {
    logic [ENT_W-1:0] entry;
    logic             valid;
  } bwd_link_t;

  typedef struct packed {
    logic             member;
    logic             any_valid;
    logic             more_than_one;
    logic [ENT_W-1:0] tail_entry;
  } chain_status_t;

endpackage

FILE: hw/rtl/lru_replacement_tracker_unit.sv
`timescale 1ns / 1ps
// Channel  | Ports                  | Transfer
// ---------+------------------------+----------------------------------
// command  | start, busy, request   | edge with start high, busy low
// result   | strobe, result         | edge ending the strobe cycle
//
// Use and detach give no result and reclaim gives one; hibernate gives
// one result per cycle from the tail, none for an empty list.
// Use, detach and reclaim each are one cell row shift; a hibernate pops the
// row's tail once per cycle. Synchronous reset empties the row at once.
// The receiver cannot stall: results are shown for one cycle only.
module lru_replacement_tracker_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  lrt_pkg::in_t  request,
  output logic          strobe,
  output lrt_pkg::out_t result
);
  import lrt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_APPLY  = 2'd1;
  localparam logic [1:0] S_REPORT = 2'd2;
  localparam logic [1:0] S_DRAIN  = 2'd3;

  logic [1:0]    state;
  in_t           cmd_q;
  cell_cmd_t     cell_cmd;
  chain_status_t status;
  logic          ent_ok;
  logic          present;
  logic          found;

  assign busy    = (state != S_IDLE);
  assign ent_ok  = int'(cmd_q.entry) < ENTRIES;
  assign present = cmd_q.requester_present && ent_ok;
  assign found   = status.any_valid && !(present && status.tail_entry == cmd_q.entry);

  always_comb begin
    cell_cmd.key = cmd_q.entry;
    cell_cmd.op  = OP_HOLD;
    case (state)
      S_APPLY: begin
        case (cmd_q.action)
          ACT_USE:     cell_cmd.op = ent_ok ? OP_MOVE : OP_HOLD;
          ACT_DETACH:  cell_cmd.op = ent_ok ? OP_REMOVE : OP_HOLD;
          ACT_RECLAIM: cell_cmd.op = (present && status.member) ? OP_MOVE : OP_HOLD;
          default:     cell_cmd.op = OP_HOLD;
        endcase
      end
      S_DRAIN: cell_cmd.op = OP_POP;
      default: cell_cmd.op = OP_HOLD;
    endcase
  end

  lrt_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cell_cmd),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= request;
            state <= (request.action == ACT_HIBERNATE) ? S_DRAIN : S_APPLY;
          end
        end
        S_APPLY: begin
          state <= (cmd_q.action == ACT_RECLAIM) ? S_REPORT : S_IDLE;
        end
        S_REPORT: begin
          strobe              <= 1'b1;
          result.victim_entry <= found ? status.tail_entry : '0;
          result.victim_found <= found;
          result.last         <= 1'b1;
          state               <= S_IDLE;
        end
        S_DRAIN: begin
          if (status.any_valid) begin
            strobe              <= 1'b1;
            result.victim_entry <= status.tail_entry;
            result.victim_found <= 1'b1;
            result.last         <= !status.more_than_one;
          end
          if (!status.more_than_one) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_strobe_after_work: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without a command in flight");

  a_no_victim_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.victim_found |-> result.victim_entry == '0)
    else $error("victim_entry nonzero without a victim");

  a_drain_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("gap in hibernate results");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last && $past(state == S_DRAIN) |-> !status.any_valid)
    else $error("list not empty after final hibernate result");

  a_empty_drain_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN && !status.any_valid |=> !strobe && state == S_IDLE)
    else $error("hibernate of an empty list misbehaved");
`endif

endmodule

FILE: hw/rtl/lrt_cell.sv
`timescale 1ns / 1ps

module lrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  lrt_pkg::cell_cmd_t cmd,
  input  lrt_pkg::fwd_link_t left_in,
  input  lrt_pkg::bwd_link_t right_in,
  output lrt_pkg::fwd_link_t right_out,
  output lrt_pkg::bwd_link_t left_out,
  output logic               tail,
  output logic [lrt_pkg::ENT_W-1:0] entry_out
);
  import lrt_pkg::*;

  logic [ENT_W-1:0] entry;
  logic             valid;
  logic             match;

  assign match = valid && (entry == cmd.key);
  assign tail  = valid && !right_in.valid;
  assign entry_out = entry;

  assign right_out.entry = entry;
  assign right_out.valid = valid;
  assign right_out.stop  = left_in.stop | match | !valid;
  assign right_out.hit   = left_in.hit | match;

  assign left_out.entry = entry;
  assign left_out.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.op)
        OP_MOVE: begin
          if (!left_in.stop) begin
            entry <= left_in.entry;
            valid <= left_in.valid;
          end
        end
        OP_REMOVE: begin
          if (right_out.hit) begin
            entry <= right_in.entry;
            valid <= right_in.valid;
          end
        end
        OP_POP: begin
          if (tail) begin
            valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/lrt_chain.sv
`timescale 1ns / 1ps

module lrt_chain (
  input  logic                  clk,
  input  logic                  rst,
  input  lrt_pkg::cell_cmd_t    cmd,
  output lrt_pkg::chain_status_t status
);
  import lrt_pkg::*;

  fwd_link_t        fwd [ENTRIES+1];
  bwd_link_t        bwd [ENTRIES+1];
  logic             tail [ENTRIES];
  logic [ENT_W-1:0] ent [ENTRIES];
  logic [ENT_W-1:0] tail_entry;

  // head is fed the key itself, so a move writes it into cell 0
  assign fwd[0].entry = cmd.key;
  assign fwd[0].valid = 1'b1;
  assign fwd[0].stop  = 1'b0;
  assign fwd[0].hit   = 1'b0;
  assign bwd[ENTRIES] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left_in   (fwd[i]),
      .right_in  (bwd[i+1]),
      .right_out (fwd[i+1]),
      .left_out  (bwd[i]),
      .tail      (tail[i]),
      .entry_out (ent[i])
    );
  end

  always_comb begin
    tail_entry = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      tail_entry = tail_entry | (tail[i] ? ent[i] : '0);
    end
  end

  assign status.member        = fwd[ENTRIES].hit;
  assign status.any_valid     = bwd[0].valid;
  assign status.more_than_one = bwd[1].valid;
  assign status.tail_entry    = tail_entry;

endmodule
